// ===== hdl/slcp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// slcp_pkg: shared types, codes and functions of the serial RGB LED parser
// Holds the input command codes, the operation codes that pass from the
// front end to the back end, the queue entry types and the color helpers.
// ----------------------------------------------------------------------------
package slcp_pkg;

  localparam int LINE_CAP = 12;

  localparam logic [3:0] LINE_OVERFLOW = 4'd13;
  localparam logic [3:0] LINE_FULL     = 4'd12;
  localparam logic [3:0] COLOR_LENGTH  = 4'd9;

  // Input command codes.
  localparam logic [1:0] CMD_CHAR = 2'd0;
  localparam logic [1:0] CMD_EOL  = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  // Operation codes from the front end to the back end.
  localparam logic [2:0] OP_NONE    = 3'd0;
  localparam logic [2:0] OP_ERROR   = 3'd1;
  localparam logic [2:0] OP_RAINBOW = 3'd2;
  localparam logic [2:0] OP_COLOR   = 3'd3;
  localparam logic [2:0] OP_TICK    = 3'd4;

  localparam logic [7:0] RAINBOW_TEXT [LINE_CAP] = '{
    8'h23, 8'h46, 8'h55, 8'h4C, 8'h4C, 8'h52,
    8'h41, 8'h49, 8'h4E, 8'h42, 8'h4F, 8'h57
  };

  localparam logic [7:0] CHAR_HASH = 8'h23;
  localparam logic [7:0] CHAR_D    = 8'h44;
  localparam logic [7:0] CHAR_6    = 8'h36;
  localparam logic [7:0] CHAR_8    = 8'h38;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [1:0] led;
    rgb_t       color;
  } op_t;

  typedef struct packed {
    rgb_t d6;
    rgb_t d7;
    rgb_t d8;
    logic format_error;
    logic rainbow_active;
  } result_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c inside {[8'h30:8'h39]}) begin
      v = c - 8'h30;
    end else if (c inside {[8'h61:8'h66]}) begin
      v = c - 8'h57;
    end else if (c inside {[8'h41:8'h46]}) begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

  // Three-segment color wheel, indexed from the top of the position range.
  function automatic rgb_t wheel_color(input logic [7:0] position);
    logic [7:0] p;
    logic [7:0] q;
    logic [9:0] t;
    rgb_t       c;
    p = 8'd255 - position;
    if (p < 8'd85) begin
      q = p;
    end else if (p < 8'd170) begin
      q = p - 8'd85;
    end else begin
      q = p - 8'd170;
    end
    t = {2'b00, q} * 10'd3;
    if (p < 8'd85) begin
      c.red   = 8'd255 - t[7:0];
      c.green = 8'd0;
      c.blue  = t[7:0];
    end else if (p < 8'd170) begin
      c.red   = 8'd0;
      c.green = t[7:0];
      c.blue  = 8'd255 - t[7:0];
    end else begin
      c.red   = t[7:0];
      c.green = 8'd255 - t[7:0];
      c.blue  = 8'd0;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/serial_rgb_led_command_parser.sv =====
`default_nettype none
// An accepted item is written to the operation queue; the back end then writes its result to
// the result queue, from which it can be popped.
// Throughput: one item per cycle while results are popped; a held receiver fills both queues.
// Reset (synchronous, rst high): both queues empty, line length zero, all LEDs off,
// rainbow mode off and wheel position zero.
// ----------------------------------------------------------------------------
// serial_rgb_led_command_parser: top level of the serial RGB LED parser
// Front end collects and decodes command lines, a two-entry operation queue
// feeds the back end that owns the LED state and the result queue.
// ----------------------------------------------------------------------------
module serial_rgb_led_command_parser (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [1:0] cmd,
  input  wire logic [7:0] ch,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      d6_red,
  output logic [7:0]      d6_green,
  output logic [7:0]      d6_blue,
  output logic [7:0]      d7_red,
  output logic [7:0]      d7_green,
  output logic [7:0]      d7_blue,
  output logic [7:0]      d8_red,
  output logic [7:0]      d8_green,
  output logic [7:0]      d8_blue,
  output logic            format_error,
  output logic            rainbow_active
);
  import slcp_pkg::*;

  logic    op_wr;
  op_t     op_in;
  logic    op_valid;
  logic    op_rd;
  op_t     op_head;
  result_t res;

  slcp_front u_front (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .cmd   (cmd),
    .ch    (ch),
    .op_wr (op_wr),
    .op    (op_in)
  );

  slcp_op_queue u_op_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (op_wr),
    .wr_op (op_in),
    .rd    (op_rd),
    .full  (full),
    .valid (op_valid),
    .head  (op_head)
  );

  slcp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (op_valid),
    .op       (op_head),
    .op_rd    (op_rd),
    .pop      (pop),
    .empty    (empty),
    .head     (res)
  );

  assign d6_red         = res.d6.red;
  assign d6_green       = res.d6.green;
  assign d6_blue        = res.d6.blue;
  assign d7_red         = res.d7.red;
  assign d7_green       = res.d7.green;
  assign d7_blue        = res.d7.blue;
  assign d8_red         = res.d8.red;
  assign d8_green       = res.d8.green;
  assign d8_blue        = res.d8.blue;
  assign format_error   = res.format_error;
  assign rainbow_active = res.rainbow_active;

endmodule
`default_nettype wire

// ===== hdl/slcp_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// slcp_front: line collection and command classification
// Stores the characters of the current line and, at end of line, decodes the
// whole line in parallel into one operation for the back end; a tick becomes
// a tick operation and any other accepted beat an empty operation.
module slcp_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic             full,
  input  wire logic [1:0]       cmd,
  input  wire logic [7:0]       ch,
  output logic                  op_wr,
  output slcp_pkg::op_t         op
);
  import slcp_pkg::*;

  logic [7:0] line_store [LINE_CAP];
  logic [3:0] line_length;
  logic       is_rainbow;
  logic       is_color;
  logic [7:0] led_code;

  assign op_wr = push && !full;

  always_comb begin
    is_rainbow = (line_length == LINE_FULL);
    for (int i = 0; i < LINE_CAP; i++) begin
      if (line_store[i] != RAINBOW_TEXT[i]) begin
        is_rainbow = 1'b0;
      end
    end
    is_color = (line_length == COLOR_LENGTH) && (line_store[0] == CHAR_HASH) &&
               (line_store[7] == CHAR_D) &&
               (line_store[8] >= CHAR_6) && (line_store[8] <= CHAR_8);
    for (int i = 1; i <= 6; i++) begin
      if (!is_hex(line_store[i])) begin
        is_color = 1'b0;
      end
    end
  end

  always_comb begin
    led_code       = line_store[8] - CHAR_6;
    op.kind        = OP_NONE;
    op.led         = led_code[1:0];
    op.color.red   = {hex_nibble(line_store[1]), hex_nibble(line_store[2])};
    op.color.green = {hex_nibble(line_store[3]), hex_nibble(line_store[4])};
    op.color.blue  = {hex_nibble(line_store[5]), hex_nibble(line_store[6])};
    case (cmd)
      CMD_EOL: begin
        if (is_rainbow) begin
          op.kind = OP_RAINBOW;
        end else if (is_color) begin
          op.kind = OP_COLOR;
        end else begin
          op.kind = OP_ERROR;
        end
      end
      CMD_TICK: op.kind = OP_TICK;
      default:  op.kind = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= 4'd0;
    end else if (op_wr) begin
      if (cmd == CMD_CHAR) begin
        if (line_length < LINE_FULL) begin
          line_length <= line_length + 4'd1;
        end else begin
          line_length <= LINE_OVERFLOW;
        end
      end else if (cmd == CMD_EOL) begin
        line_length <= 4'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op_wr && (cmd == CMD_CHAR) && (line_length < LINE_FULL)) begin
      line_store[line_length] <= ch;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/slcp_op_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// slcp_op_queue: two-entry queue of decoded operations
// Decouples the line front end from the LED back end.
// ----------------------------------------------------------------------------
module slcp_op_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr,
  input  wire slcp_pkg::op_t wr_op,
  input  wire logic          rd,
  output logic               full,
  output logic               valid,
  output slcp_pkg::op_t      head
);
  import slcp_pkg::*;

  op_t        mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr) begin
        wr_ptr <= !wr_ptr;
      end
      if (rd) begin
        rd_ptr <= !rd_ptr;
      end
      if (wr && !rd) begin
        count <= count + 2'd1;
      end else if (rd && !wr) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_op;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/slcp_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// slcp_back: LED state and result queue
// Carries out one operation per cycle, while the result queue has room, on the
// LED colors, the rainbow mode and the wheel position, and queues the state
// after each beat as a result.
module slcp_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          op_valid,
  input  wire slcp_pkg::op_t op,
  output logic               op_rd,
  input  wire logic          pop,
  output logic               empty,
  output slcp_pkg::result_t  head
);
  import slcp_pkg::*;

  rgb_t       leds [3];
  logic       rainbow;
  logic [7:0] wheel;

  rgb_t       leds_next [3];
  logic       rainbow_next;
  logic [7:0] wheel_next;
  logic       err_next;
  rgb_t       wheel_rgb;
  result_t    res_next;

  result_t    rq [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       res_pop;

  assign empty   = (count == 2'd0);
  assign res_pop = pop && !empty;
  assign op_rd   = op_valid && ((count != 2'd2) || res_pop);
  assign head    = rq[rd_ptr];
  assign wheel_rgb = wheel_color(wheel);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      leds_next[i] = leds[i];
    end
    rainbow_next = rainbow;
    wheel_next   = wheel;
    err_next     = 1'b0;
    case (op.kind)
      OP_ERROR:   err_next = 1'b1;
      OP_RAINBOW: rainbow_next = 1'b1;
      OP_COLOR: begin
        rainbow_next = 1'b0;
        for (int i = 0; i < 3; i++) begin
          if (op.led == 2'(i)) begin
            leds_next[i] = op.color;
          end
        end
      end
      OP_TICK: begin
        if (rainbow) begin
          for (int i = 0; i < 3; i++) begin
            leds_next[i] = wheel_rgb;
          end
          wheel_next = wheel + 8'd1;
        end
      end
      default: ;
    endcase
    res_next.d6             = leds_next[0];
    res_next.d7             = leds_next[1];
    res_next.d8             = leds_next[2];
    res_next.format_error   = err_next;
    res_next.rainbow_active = rainbow_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        leds[i] <= '0;
      end
      rainbow <= 1'b0;
      wheel   <= 8'd0;
      wr_ptr  <= 1'b0;
      rd_ptr  <= 1'b0;
      count   <= 2'd0;
    end else begin
      if (op_rd) begin
        for (int i = 0; i < 3; i++) begin
          leds[i] <= leds_next[i];
        end
        rainbow <= rainbow_next;
        wheel   <= wheel_next;
        wr_ptr  <= !wr_ptr;
      end
      if (res_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (op_rd && !res_pop) begin
        count <= count + 2'd1;
      end else if (res_pop && !op_rd) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op_rd) begin
      rq[wr_ptr] <= res_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/slcp_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// slcp_checker: port-level checks of the serial RGB LED parser
// Watches reset, queue occupancy and result holding from the top-level ports.
// ----------------------------------------------------------------------------
module slcp_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       push,
  input wire logic       full,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] d6_red,
  input wire logic [7:0] d6_green,
  input wire logic [7:0] d6_blue,
  input wire logic [7:0] d7_red,
  input wire logic [7:0] d7_green,
  input wire logic [7:0] d7_blue,
  input wire logic [7:0] d8_red,
  input wire logic [7:0] d8_green,
  input wire logic [7:0] d8_blue,
  input wire logic       format_error,
  input wire logic       rainbow_active
);

  // Reset leaves both queues empty.
  a_reset_clears: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not empty after reset");

  // A beat needs an accepted item; with none right after reset nothing appears.
  a_no_phantom: assert property (@(posedge clk)
    rst ##1 (!rst && !(push && !full)) |=> empty)
    else $error("result appeared without an accepted item");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("waiting result vanished");

  a_fields_held: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> ($stable(format_error) && $stable(rainbow_active) &&
                          $stable(d6_red) && $stable(d6_green) && $stable(d6_blue) &&
                          $stable(d7_red) && $stable(d7_green) && $stable(d7_blue) &&
                          $stable(d8_red) && $stable(d8_green) && $stable(d8_blue)))
    else $error("waiting result changed");

endmodule

bind serial_rgb_led_command_parser slcp_checker u_checker (.*);
`default_nettype wire

// ===== verif/serial_rgb_led_command_parser_checker.sv =====
// ----------------------------------------------------------------------------
// serial_rgb_led_command_parser_checker: prediction and comparison
// Watches both queue-style channels of the LED command parser. Each accepted
// input beat updates a private copy of the line buffer and LED state. The
// predicted LED state is queued. Each popped result beat is compared field
// by field with the oldest queued prediction.
// ----------------------------------------------------------------------------
module serial_rgb_led_command_parser_checker
  import slcp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire logic       full,
  input  wire logic [1:0] cmd,
  input  wire logic [7:0] ch,
  input  wire logic       empty,
  input  wire logic       pop,
  input  wire logic [7:0] d6_red,
  input  wire logic [7:0] d6_green,
  input  wire logic [7:0] d6_blue,
  input  wire logic [7:0] d7_red,
  input  wire logic [7:0] d7_green,
  input  wire logic [7:0] d7_blue,
  input  wire logic [7:0] d8_red,
  input  wire logic [7:0] d8_green,
  input  wire logic [7:0] d8_blue,
  input  wire logic       format_error,
  input  wire logic       rainbow_active,
  output int              fail_count,
  output int              pending
);

  localparam logic [95:0] RAINBOW_WORD = "#FULLRAINBOW";

  logic [7:0] line_buf [12];
  logic [3:0] line_len;
  rgb_t       leds [3];
  logic       rainbow_mode;
  logic [7:0] wheel_pos;
  result_t    led_state_q [$];

  // Returns {valid, value} for one ASCII hex digit of either case.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [7:0] d;
    if (c >= "0" && c <= "9") begin
      d = c - "0";
      return {1'b1, d[3:0]};
    end else if (c >= "a" && c <= "f") begin
      d = c - "a" + 8'd10;
      return {1'b1, d[3:0]};
    end else if (c >= "A" && c <= "F") begin
      d = c - "A" + 8'd10;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

  function automatic logic [7:0] hex_pair(input logic [7:0] hi, input logic [7:0] lo);
    logic [4:0] h;
    logic [4:0] l;
    h = hex_decode(hi);
    l = hex_decode(lo);
    return {h[3:0], l[3:0]};
  endfunction

  // The wheel runs backwards from the top of the position range.
  function automatic rgb_t wheel_rgb(input logic [7:0] pos);
    int   p;
    int   q;
    rgb_t c;
    p = 255 - int'(pos);
    if (p < 85) begin
      c.red   = 8'(255 - 3 * p);
      c.green = 8'd0;
      c.blue  = 8'(3 * p);
    end else if (p < 170) begin
      q = p - 85;
      c.red   = 8'd0;
      c.green = 8'(3 * q);
      c.blue  = 8'(255 - 3 * q);
    end else begin
      q = p - 170;
      c.red   = 8'(3 * q);
      c.green = 8'(255 - 3 * q);
      c.blue  = 8'd0;
    end
    return c;
  endfunction

  function automatic logic line_is_rainbow();
    logic hit;
    hit = (line_len == 4'd12);
    for (int i = 0; i < 12; i++) begin
      if (hit && line_buf[i] != RAINBOW_WORD[95 - 8 * i -: 8]) begin
        hit = 1'b0;
      end
    end
    return hit;
  endfunction

  function automatic logic line_is_color();
    logic       hit;
    logic [4:0] h;
    hit = (line_len == 4'd9) && (line_buf[0] == "#");
    for (int i = 1; i <= 6; i++) begin
      h = hex_decode(line_buf[i]);
      if (hit && !h[4]) begin
        hit = 1'b0;
      end
    end
    if (hit) begin
      hit = (line_buf[7] == "D") && (line_buf[8] >= "6") && (line_buf[8] <= "8");
    end
    return hit;
  endfunction

  function automatic result_t predict_led_state(input logic [1:0] op, input logic [7:0] c);
    result_t    r;
    rgb_t       wc;
    logic [7:0] sel;
    logic       bad;
    bad = 1'b0;
    case (op)
      CMD_CHAR: begin
        if (line_len < 4'd12) begin
          line_buf[line_len] = c;
          line_len = line_len + 4'd1;
        end else begin
          line_len = 4'd13;
        end
      end
      CMD_EOL: begin
        if (line_is_rainbow()) begin
          rainbow_mode = 1'b1;
        end else if (line_is_color()) begin
          rainbow_mode = 1'b0;
          sel = line_buf[8] - "6";
          wc.red   = hex_pair(line_buf[1], line_buf[2]);
          wc.green = hex_pair(line_buf[3], line_buf[4]);
          wc.blue  = hex_pair(line_buf[5], line_buf[6]);
          leds[sel[1:0]] = wc;
        end else begin
          bad = 1'b1;
        end
        line_len = 4'd0;
      end
      CMD_TICK: begin
        if (rainbow_mode) begin
          wc = wheel_rgb(wheel_pos);
          leds[0] = wc;
          leds[1] = wc;
          leds[2] = wc;
          wheel_pos = wheel_pos + 8'd1;
        end
      end
      default: begin
      end
    endcase
    r.d6             = leds[0];
    r.d7             = leds[1];
    r.d8             = leds[2];
    r.format_error   = bad;
    r.rainbow_active = rainbow_mode;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      for (int i = 0; i < 12; i++) begin
        line_buf[i] = 8'd0;
      end
      for (int i = 0; i < 3; i++) begin
        leds[i] = '0;
      end
      line_len     = 4'd0;
      rainbow_mode = 1'b0;
      wheel_pos    = 8'd0;
      led_state_q.delete();
      fail_count   = 0;
    end else begin
      // Compare before predicting: a result never leaves in the cycle its
      // item is taken.
      if (pop && !empty) begin
        if (led_state_q.size() == 0) begin
          $error("result beat popped with no item pending");
          fail_count++;
        end else begin
          want = led_state_q.pop_front();
          check_field("d6_red", want.d6.red, d6_red);
          check_field("d6_green", want.d6.green, d6_green);
          check_field("d6_blue", want.d6.blue, d6_blue);
          check_field("d7_red", want.d7.red, d7_red);
          check_field("d7_green", want.d7.green, d7_green);
          check_field("d7_blue", want.d7.blue, d7_blue);
          check_field("d8_red", want.d8.red, d8_red);
          check_field("d8_green", want.d8.green, d8_green);
          check_field("d8_blue", want.d8.blue, d8_blue);
          check_field("format_error", want.format_error, format_error);
          check_field("rainbow_active", want.rainbow_active, rainbow_active);
        end
      end
      if (push && !full) begin
        led_state_q.push_back(predict_led_state(cmd, ch));
      end
    end
    pending = led_state_q.size();
  end

endmodule

// ===== verif/serial_rgb_led_command_parser_tb.sv =====
// ----------------------------------------------------------------------------
// serial_rgb_led_command_parser_tb: testbench top of the LED command parser
// Drives command lines, rainbow ticks and noise into the parser. The sender
// and receiver idle in several phases, with one long receiver hold-off that
// fills the block. A checker beside the block predicts every result beat.
// ----------------------------------------------------------------------------
module serial_rgb_led_command_parser_tb;
  import slcp_pkg::*;

  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam int         TOTAL_ITEMS  = 1650;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         DRAIN_CYCLES = 10;
  localparam int         CYCLE_LIMIT  = 200000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic [1:0] cmd = CMD_CHAR;
  logic [7:0] ch = 8'd0;
  logic       pop = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] d6_red, d6_green, d6_blue;
  logic [7:0] d7_red, d7_green, d7_blue;
  logic [7:0] d8_red, d8_green, d8_blue;
  logic       format_error;
  logic       rainbow_active;
  int         fail_count;
  int         pending;

  int         send_idle_pct = 0;
  int         pop_idle_pct = 0;
  logic       stall_request = 1'b0;
  int         item_count = 0;
  logic [7:0] line_q [$];

  serial_rgb_led_command_parser u_top (.*);

  serial_rgb_led_command_parser_checker u_checker (.*);

  always #5 clk = ~clk;

  // Receiver: random pops, or one long hold-off on request.
  initial begin : receiver
    forever begin
      @(negedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        pop <= ($urandom_range(99) >= pop_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [7:0] any_byte();
    int r;
    r = $urandom_range(9);
    if (r == 0) begin
      return 8'h00;
    end else if (r == 1) begin
      return 8'hFF;
    end
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] hex_char();
    logic [7:0] v;
    v = 8'($urandom_range(15));
    if (v < 8'd10) begin
      return "0" + v;
    end
    return ($urandom_range(1) ? "a" : "A") + v - 8'd10;
  endfunction

  // Characters that sit just beside the ones a command accepts, or any byte half the time.
  function automatic logic [7:0] near_miss();
    string s;
    s = "/:@G`gd59D7#";
    if ($urandom_range(1)) begin
      return any_byte();
    end
    return s[$urandom_range(s.len() - 1)];
  endfunction

  task automatic load_text(input string s);
    line_q = {};
    for (int i = 0; i < s.len(); i++) begin
      line_q.push_back(s[i]);
    end
  endtask

  task automatic build_color_line();
    line_q = {};
    line_q.push_back("#");
    repeat (6) line_q.push_back(hex_char());
    line_q.push_back("D");
    line_q.push_back(8'("6" + $urandom_range(2)));
  endtask

  // One beat: random gap first, then hold until the block takes it.
  task automatic send_beat(input logic [1:0] op, input logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push <= 1'b1;
    cmd  <= op;
    ch   <= c;
    @(posedge clk);
    while (full) @(posedge clk);
    if (op != CMD_UNUSED) begin
      item_count++;
    end
  endtask

  // Sends the buffered line and its end of line, with a stray tick now and then.
  task automatic send_line();
    foreach (line_q[i]) begin
      if ($urandom_range(99) < 5) begin
        send_beat(CMD_TICK, any_byte());
      end
      send_beat(CMD_CHAR, line_q[i]);
    end
    send_beat(CMD_EOL, any_byte());
  endtask

  initial begin : stimulus
    int phase;
    int r;
    int n;
    int pos;
    logic pressure_done;
    pressure_done = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: tick while rainbow is off, unused code, empty line, rainbow,
    // ticks in rainbow mode and a mixed-case color command.
    send_beat(CMD_TICK, 8'h00);
    send_beat(CMD_UNUSED, 8'hFF);
    send_beat(CMD_EOL, 8'hA5);
    load_text("#FULLRAINBOW");
    send_line();
    send_beat(CMD_TICK, 8'hFF);
    send_beat(CMD_TICK, 8'h5A);
    load_text("#fFaA09D8");
    send_line();

    while (item_count < TOTAL_ITEMS) begin
      phase = item_count * 5 / TOTAL_ITEMS;
      case (phase)
        0: begin
          send_idle_pct = 0;
          pop_idle_pct  = 0;
        end
        1: begin
          send_idle_pct = 57;
          pop_idle_pct  = 0;
        end
        2: begin
          send_idle_pct = 0;
          pop_idle_pct  = 57;
        end
        3: begin
          send_idle_pct = 17;
          pop_idle_pct  = 17;
        end
        default: begin
          send_idle_pct = 0;
          pop_idle_pct  = 0;
          if (!pressure_done) begin
            stall_request = 1'b1;
            pressure_done = 1'b1;
          end
        end
      endcase

      r = $urandom_range(99);
      if (r < 35) begin
        build_color_line();
        send_line();
      end else if (r < 45) begin
        load_text("#FULLRAINBOW");
        send_line();
      end else if (r < 60) begin
        n = $urandom_range(1) ? $urandom_range(1, 4) : $urandom_range(20, 60);
        repeat (n) send_beat(CMD_TICK, any_byte());
      end else if (r < 75) begin
        // A command with one character changed, dropped or added.
        if ($urandom_range(2) != 0) begin
          build_color_line();
        end else begin
          load_text("#FULLRAINBOW");
        end
        pos = $urandom_range(line_q.size() - 1);
        case ($urandom_range(2))
          0: line_q[pos] = near_miss();
          1: line_q.delete(pos);
          default: line_q.push_back(near_miss());
        endcase
        send_line();
      end else if (r < 82) begin
        // Overlong line: the buffer saturates and the line is rejected.
        if ($urandom_range(1)) begin
          load_text("#FULLRAINBOW");
          n = $urandom_range(1, 3);
        end else begin
          line_q = {};
          n = $urandom_range(13, 16);
        end
        repeat (n) line_q.push_back(any_byte());
        send_line();
      end else if (r < 92) begin
        line_q = {};
        n = $urandom_range(5);
        repeat (n) line_q.push_back(any_byte());
        send_line();
      end else begin
        send_beat(CMD_UNUSED, any_byte());
      end
    end

    @(negedge clk);
    push <= 1'b0;
    pop_idle_pct = 0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== serial_rgb_led_command_parser.f =====
hdl/slcp_pkg.sv
hdl/slcp_front.sv
hdl/slcp_op_queue.sv
hdl/slcp_back.sv
hdl/serial_rgb_led_command_parser.sv
hdl/slcp_checker.sv
verif/serial_rgb_led_command_parser_checker.sv
verif/serial_rgb_led_command_parser_tb.sv
